// ===== rtl/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared widths, constants and register codes of the dielectric Fresnel block.
// ----------------------------------------------------------------------------
package fdr_pkg;

	localparam int OUT_FRAC_BITS_DEF = 16;

	localparam int IDX_W  = 16;            // Q4.12 refractive index
	localparam int COS_W  = 16;            // Q2.14 cosine
	localparam int CI_W   = 15;            // clamped |cos|, up to 1.0
	localparam int SQ2_W  = 32;            // squared index, Q8.24
	localparam int RAD_W  = 60;            // radicand, Q52
	localparam int ROOT_W = RAD_W / 2;     // square root, Q26
	localparam int DIV_W  = 32;            // divider operands and quotient

	localparam logic signed [COS_W-1:0] COS_ONE   = 16'sd16384;
	localparam logic signed [COS_W-1:0] COS_M_ONE = -16'sd16384;

	localparam logic [IDX_W-1:0] IDX_INC_RST = 16'd4096;
	localparam logic [IDX_W-1:0] IDX_TRN_RST = 16'd6144;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_INC = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRN = 8'd1;

	// values that ride alongside the square-root cells
	typedef struct packed {
		logic              tir;
		logic [CI_W-1:0]   ci;
		logic [IDX_W-1:0]  ei;
		logic [SQ2_W-1:0]  et2;
	} sq_side_t;

	// flags that ride alongside the divider cells
	typedef struct packed {
		logic tir;
		logic z1;
		logic z2;
	} div_side_t;

endpackage

// ===== rtl/fresnel_dielectric_reflectance.sv =====
// throughput: one cosine per cycle, busy is never raised
// the depth comes mostly from 30 square-root cells and 32 divider cells in a row
// results come out on done for one cycle, the receiver cannot stall
// reset clears the valid pipeline and sets the indices to 1.0 and 1.5
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance import fdr_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [COS_W-1:0]  cos_incident,
	output logic                     done,
	output logic [OUT_FRAC_BITS:0]   reflectance,
	output logic                     total_internal,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [IDX_W-1:0]         cfg_data
);

	localparam int OUT_W  = OUT_FRAC_BITS + 1;
	localparam int SQ_N   = ROOT_W;
	localparam int DV_N   = DIV_W;
	localparam int LAT    = 4 + SQ_N + 3 + DV_N + 2;
	localparam int RSH    = 63 - OUT_FRAC_BITS;
	localparam logic [63:0] RND = 64'(1) << (62 - OUT_FRAC_BITS);
	localparam logic [OUT_W-1:0] REFL_ONE = OUT_W'(1) << OUT_FRAC_BITS;

	logic [IDX_W-1:0] idx_inc_q, idx_trn_q;
	logic [LAT-1:0]   vld_q;
	logic             accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_inc_q <= IDX_INC_RST;
			idx_trn_q <= IDX_TRN_RST;
			vld_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index == CFG_IDX_INC) idx_inc_q <= cfg_data;
			if (cfg_valid && cfg_ready && cfg_index == CFG_IDX_TRN) idx_trn_q <= cfg_data;
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// stage 1: clamp and pick the side the ray comes from
	logic signed [COS_W-1:0] c_cl;
	logic [CI_W-1:0]  ci_s1;
	logic [IDX_W-1:0] ei_s1, et_s1;

	always_comb begin
		c_cl = cos_incident;
		if (cos_incident > COS_ONE) c_cl = COS_ONE;
		if (cos_incident < COS_M_ONE) c_cl = COS_M_ONE;
	end

	always_ff @(posedge clk) begin
		if (c_cl > 16'sd0) begin
			ci_s1 <= CI_W'(c_cl);
			ei_s1 <= idx_inc_q;
			et_s1 <= idx_trn_q;
		end else begin
			ci_s1 <= CI_W'(-c_cl);
			ei_s1 <= idx_trn_q;
			et_s1 <= idx_inc_q;
		end
	end

	// stage 2: squares
	logic [28:0]      ci2_s2;
	logic [SQ2_W-1:0] ei2_s2, et2_s2;
	logic [CI_W-1:0]  ci_s2;
	logic [IDX_W-1:0] ei_s2;

	always_ff @(posedge clk) begin
		ci2_s2 <= 29'(ci_s1 * ci_s1);
		ei2_s2 <= SQ2_W'(ei_s1 * ei_s1);
		et2_s2 <= SQ2_W'(et_s1 * et_s1);
		ci_s2  <= ci_s1;
		ei_s2  <= ei_s1;
	end

	// stage 3: ei^2 * sin^2
	logic [28:0]      s2v;
	logic [60:0]      prod_s3;
	logic [SQ2_W-1:0] et2_s3;
	logic [CI_W-1:0]  ci_s3;
	logic [IDX_W-1:0] ei_s3;

	assign s2v = 29'(29'h1000_0000 - ci2_s2);

	always_ff @(posedge clk) begin
		prod_s3 <= 61'(ei2_s2 * s2v);
		et2_s3  <= et2_s2;
		ci_s3   <= ci_s2;
		ei_s3   <= ei_s2;
	end

	// stage 4: total internal reflection test and radicand
	logic [60:0]      et2_sh;
	logic             tir_c;
	logic [RAD_W-1:0] rad_s4;
	sq_side_t         side_s4;

	assign et2_sh = 61'(et2_s3) << 28;
	assign tir_c  = prod_s3 >= et2_sh;

	always_ff @(posedge clk) begin
		rad_s4      <= tir_c ? '0 : RAD_W'(et2_sh - prod_s3);
		side_s4.tir <= tir_c;
		side_s4.ci  <= ci_s3;
		side_s4.ei  <= ei_s3;
		side_s4.et2 <= et2_s3;
	end

	// square-root cells, most significant root bit first
	logic [RAD_W-1:0]  sq_rem  [SQ_N];
	logic [ROOT_W-1:0] sq_root [SQ_N];
	sq_side_t          sq_side [SQ_N];

	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		if (j == 0) begin : g_first
			fdr_sqrt_cell #(.BIT(SQ_N - 1 - j)) u_cell (
				.clk(clk), .rem_in(rad_s4), .root_in('0),
				.rem_s(sq_rem[j]), .root_s(sq_root[j])
			);
			always_ff @(posedge clk) sq_side[j] <= side_s4;
		end else begin : g_next
			fdr_sqrt_cell #(.BIT(SQ_N - 1 - j)) u_cell (
				.clk(clk), .rem_in(sq_rem[j-1]), .root_in(sq_root[j-1]),
				.rem_s(sq_rem[j]), .root_s(sq_root[j])
			);
			always_ff @(posedge clk) sq_side[j] <= sq_side[j-1];
		end
	end

	// ratio operand products
	sq_side_t          sd;
	logic [ROOT_W-1:0] w;
	logic [46:0]       a1_m1;
	logic [45:0]       b1_m1;
	logic [30:0]       a2_m1;
	logic [ROOT_W-1:0] w_m1;
	logic              tir_m1;

	assign sd = sq_side[SQ_N-1];
	assign w  = sq_root[SQ_N-1];

	always_ff @(posedge clk) begin
		a1_m1  <= 47'(sd.et2 * sd.ci);
		b1_m1  <= 46'(sd.ei * w);
		a2_m1  <= 31'(sd.ei * sd.ci);
		w_m1   <= w;
		tir_m1 <= sd.tir;
	end

	// numerators and denominators
	logic [47:0]      n1_m2, d1_m2;
	logic [DIV_W-1:0] n2_m2, d2_m2;
	logic             tir_m2;

	always_ff @(posedge clk) begin
		n1_m2  <= (48'(a1_m1) >= 48'(b1_m1)) ? 48'(a1_m1) - 48'(b1_m1)
		                                     : 48'(b1_m1) - 48'(a1_m1);
		d1_m2  <= 48'(a1_m1) + 48'(b1_m1);
		n2_m2  <= (DIV_W'(a2_m1) >= DIV_W'(w_m1)) ? DIV_W'(a2_m1) - DIV_W'(w_m1)
		                                          : DIV_W'(w_m1) - DIV_W'(a2_m1);
		d2_m2  <= DIV_W'(a2_m1) + DIV_W'(w_m1);
		tir_m2 <= tir_m1;
	end

	// bring the parallel pair below 2^32
	logic [4:0]       nsh;
	logic [47:0]      n1_sh, d1_sh;
	logic [DIV_W-1:0] n1_nm, d1_nm, n2_nm, d2_nm;
	div_side_t        side_nm;

	always_comb begin
		nsh = '0;
		for (int i = 0; i < 16; i++) begin
			if (d1_m2[DIV_W + i]) nsh = 5'(i + 1);
		end
		n1_sh = n1_m2 >> nsh;
		d1_sh = d1_m2 >> nsh;
	end

	always_ff @(posedge clk) begin
		n1_nm       <= n1_sh[DIV_W-1:0];
		d1_nm       <= d1_sh[DIV_W-1:0];
		n2_nm       <= n2_m2;
		d2_nm       <= d2_m2;
		side_nm.tir <= tir_m2;
		side_nm.z1  <= d1_m2 == '0;
		side_nm.z2  <= d2_m2 == '0;
	end

	// two divider lanes of cells, quotient bit 31 first
	logic [DIV_W-1:0] dv1_rem [DV_N], dv1_den [DV_N], dv1_quo [DV_N];
	logic [DIV_W-1:0] dv2_rem [DV_N], dv2_den [DV_N], dv2_quo [DV_N];
	div_side_t        dv_side [DV_N];

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		if (j == 0) begin : g_first
			fdr_div_cell #(.BIT(DV_N - 1 - j)) u_lane1 (
				.clk(clk), .rem_in({1'b0, n1_nm}), .den_in(d1_nm), .quo_in('0),
				.rem_s(dv1_rem[j]), .den_s(dv1_den[j]), .quo_s(dv1_quo[j])
			);
			fdr_div_cell #(.BIT(DV_N - 1 - j)) u_lane2 (
				.clk(clk), .rem_in({1'b0, n2_nm}), .den_in(d2_nm), .quo_in('0),
				.rem_s(dv2_rem[j]), .den_s(dv2_den[j]), .quo_s(dv2_quo[j])
			);
			always_ff @(posedge clk) dv_side[j] <= side_nm;
		end else begin : g_next
			fdr_div_cell #(.BIT(DV_N - 1 - j)) u_lane1 (
				.clk(clk), .rem_in({dv1_rem[j-1], 1'b0}), .den_in(dv1_den[j-1]),
				.quo_in(dv1_quo[j-1]),
				.rem_s(dv1_rem[j]), .den_s(dv1_den[j]), .quo_s(dv1_quo[j])
			);
			fdr_div_cell #(.BIT(DV_N - 1 - j)) u_lane2 (
				.clk(clk), .rem_in({dv2_rem[j-1], 1'b0}), .den_in(dv2_den[j-1]),
				.quo_in(dv2_quo[j-1]),
				.rem_s(dv2_rem[j]), .den_s(dv2_den[j]), .quo_s(dv2_quo[j])
			);
			always_ff @(posedge clk) dv_side[j] <= dv_side[j-1];
		end
	end

	// squares of the two ratios, a zero denominator counts as ratio one
	div_side_t        dsd;
	logic [DIV_W-1:0] r1, r2;
	logic [63:0]      p1_sq, p2_sq;
	logic             tir_sq;

	assign dsd = dv_side[DV_N-1];
	assign r1  = dsd.z1 ? 32'h8000_0000 : dv1_quo[DV_N-1];
	assign r2  = dsd.z2 ? 32'h8000_0000 : dv2_quo[DV_N-1];

	always_ff @(posedge clk) begin
		p1_sq  <= r1 * r1;
		p2_sq  <= r2 * r2;
		tir_sq <= dsd.tir;
	end

	// average and round half up
	logic [63:0] sum_rnd;

	assign sum_rnd = p1_sq + p2_sq + RND;

	always_ff @(posedge clk) begin
		reflectance    <= tir_sq ? REFL_ONE : sum_rnd[RSH +: OUT_W];
		total_internal <= tir_sq;
	end

	assign done = vld_q[LAT-1];

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching start beat");

	a_tir_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && total_internal |-> reflectance == REFL_ONE)
		else $error("total internal reflection with reflectance other than one");

	a_refl_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> reflectance <= REFL_ONE)
		else $error("reflectance above one");

	a_cfg_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_IDX_INC |=> idx_inc_q == $past(cfg_data))
		else $error("incident index write lost");

endmodule

// ===== rtl/fdr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// fdr_sqrt_cell
// One digit of a restoring square root: settles root bit BIT and passes on.
// ----------------------------------------------------------------------------
module fdr_sqrt_cell import fdr_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic [RAD_W-1:0]  rem_in,
	input  logic [ROOT_W-1:0] root_in,
	output logic [RAD_W-1:0]  rem_s,
	output logic [ROOT_W-1:0] root_s
);

	logic [RAD_W:0] trial;
	logic           ge;

	// (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
	always_comb begin
		trial = ((RAD_W+1)'(root_in) << (BIT + 1)) | ((RAD_W+1)'(1) << (2 * BIT));
		ge    = {1'b0, rem_in} >= trial;
	end

	always_ff @(posedge clk) begin
		rem_s  <= ge ? rem_in - trial[RAD_W-1:0] : rem_in;
		root_s <= root_in | (ROOT_W'(ge) << BIT);
	end

endmodule

// ===== rtl/fdr_div_cell.sv =====
// ----------------------------------------------------------------------------
// fdr_div_cell
// One step of a restoring divider: settles quotient bit BIT and passes on.
// ----------------------------------------------------------------------------
module fdr_div_cell import fdr_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic             clk,
	input  logic [DIV_W:0]   rem_in,
	input  logic [DIV_W-1:0] den_in,
	input  logic [DIV_W-1:0] quo_in,
	output logic [DIV_W-1:0] rem_s,
	output logic [DIV_W-1:0] den_s,
	output logic [DIV_W-1:0] quo_s
);

	logic ge;

	assign ge = rem_in >= {1'b0, den_in};

	always_ff @(posedge clk) begin
		rem_s <= ge ? DIV_W'(rem_in - {1'b0, den_in}) : rem_in[DIV_W-1:0];
		den_s <= den_in;
		quo_s <= quo_in | (DIV_W'(ge) << BIT);
	end

endmodule
